// ===== sv/cab_pkg.sv =====
// cab_pkg: shared constants, types and pixel helpers for the alpha blend blitter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package cab_pkg;

    localparam int FB_BITS         = 13;
    localparam int PITCH_BITS      = 15;
    localparam int BPP_BITS        = 3;
    localparam int ALPHA_BITS      = 8;
    localparam int PIX_BITS        = 32;
    localparam int OUT_OFF_BITS    = 28;
    localparam int CFG_IDX_BITS    = 4;
    localparam int CFG_DATA_BITS   = 16;
    localparam int DEF_COORD_BITS  = 14;
    localparam int DEF_OFFSET_BITS = 28;

    localparam logic [BPP_BITS-1:0]   BPP_RESET    = 3'd4;
    localparam logic [ALPHA_BITS-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]            ALPHA_BYTE   = 8'hFF;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_PIXEL = 1'b1
    } item_kind_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FB_WIDTH        = CFG_IDX_BITS'(0),
        REG_FB_HEIGHT       = CFG_IDX_BITS'(1),
        REG_ROW_PITCH       = CFG_IDX_BITS'(2),
        REG_BYTES_PER_PIXEL = CFG_IDX_BITS'(3)
    } cfg_reg_t;

    // Raster position and latched rectangle context
    typedef struct packed {
        logic                  active;
        logic                  last;
        logic [FB_BITS-1:0]    row;
        logic [FB_BITS-1:0]    col;
        logic [FB_BITS-1:0]    clip_w;
        logic [FB_BITS-1:0]    clip_h;
        logic [FB_BITS-1:0]    dst_row;
        logic [FB_BITS-1:0]    dst_x0;
        logic [ALPHA_BITS-1:0] alpha;
    } rect_ctx_t;

    // Out-of-range pixel sizes behave as four bytes
    function automatic logic [BPP_BITS-1:0] pixel_size(input logic [BPP_BITS-1:0] bpp);
        logic [BPP_BITS-1:0] size;
        if (bpp inside {[3'd1:3'd4]}) begin
            size = bpp;
        end else begin
            size = 3'd4;
        end
        return size;
    endfunction

    function automatic logic [PIX_BITS-1:0] pixel_mask(input logic [BPP_BITS-1:0] size);
        logic [PIX_BITS-1:0] mask;
        case (size)
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
        return mask;
    endfunction

    // (s*a + d*(255-a)) / 255, divide done as (x + (x>>8) + 1) >> 8, exact up to 255*255
    function automatic logic [7:0] blend_channel(input logic [7:0] s, input logic [7:0] d,
                                                 input logic [ALPHA_BITS-1:0] a);
        logic [15:0] acc;
        logic [15:0] quo;
        acc = 16'(s) * 16'(a) + 16'(d) * 16'(ALPHA_OPAQUE - a);
        quo = (acc + {8'd0, acc[15:8]} + 16'd1) >> 8;
        return quo[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/cab_blend.sv =====
// cab_blend: per-pixel constant alpha blend or copy, masked to the pixel size.
// Depends on cab_pkg.
`default_nettype none

module cab_blend
    import cab_pkg::*;
(
    input  wire logic [PIX_BITS-1:0]   src_px,
    input  wire logic [PIX_BITS-1:0]   dst_px,
    input  wire logic [ALPHA_BITS-1:0] alpha,
    input  wire logic [BPP_BITS-1:0]   bpp_cfg,
    output logic      [PIX_BITS-1:0]   pixel_out
);

    logic [PIX_BITS-1:0] mask;
    logic [PIX_BITS-1:0] src_m;
    logic [PIX_BITS-1:0] dst_m;
    logic [PIX_BITS-1:0] mixed;

    assign mask  = pixel_mask(pixel_size(bpp_cfg));
    assign src_m = src_px & mask;
    assign dst_m = dst_px & mask;

    always_comb begin
        mixed = {ALPHA_BYTE, 24'd0};
        for (int ch = 0; ch < 3; ch++) begin
            mixed[8*ch +: 8] = blend_channel(src_m[8*ch +: 8], dst_m[8*ch +: 8], alpha);
        end
    end

    assign pixel_out = (alpha == ALPHA_OPAQUE) ? src_m : (mixed & mask);

endmodule

`default_nettype wire

// ===== sv/cab_addr.sv =====
// cab_addr: destination and source byte offsets of the current raster position.
// Depends on cab_pkg; offsets wrap modulo 2^OFFSET_BITS.
`default_nettype none

module cab_addr
    import cab_pkg::*;
#(
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  wire logic        [FB_BITS-1:0]     dst_row,
    input  wire logic        [FB_BITS-1:0]     dst_x0,
    input  wire logic        [FB_BITS-1:0]     col,
    input  wire logic        [PITCH_BITS-1:0]  row_pitch,
    input  wire logic        [BPP_BITS-1:0]    bpp_cfg,
    input  wire logic        [OFFSET_BITS-1:0] src_row,
    input  wire logic signed [COORD_BITS:0]    src_x0,
    output logic             [OFFSET_BITS-1:0] dst_off,
    output logic             [OFFSET_BITS-1:0] src_off
);

    // Multiply by a pixel size of one to four bytes with shifts and one add
    function automatic logic [OFFSET_BITS-1:0] scale(input logic [OFFSET_BITS-1:0] x,
                                                     input logic [BPP_BITS-1:0] size);
        logic [OFFSET_BITS-1:0] y;
        case (size)
            3'd1:    y = x;
            3'd2:    y = x << 1;
            3'd3:    y = (x << 1) + x;
            default: y = x << 2;
        endcase
        return y;
    endfunction

    logic [BPP_BITS-1:0]           size;
    logic [FB_BITS+PITCH_BITS-1:0] dst_prod;
    logic [FB_BITS:0]              dst_x;
    logic [OFFSET_BITS-1:0]        src_pos;

    assign size     = pixel_size(bpp_cfg);
    assign dst_prod = dst_row * row_pitch;
    assign dst_x    = {1'b0, dst_x0} + {1'b0, col};
    assign dst_off  = OFFSET_BITS'(dst_prod) + scale(OFFSET_BITS'(dst_x), size);

    assign src_pos  = src_row + OFFSET_BITS'(src_x0) + OFFSET_BITS'(col);
    assign src_off  = scale(src_pos, size);

endmodule

`default_nettype wire

// ===== sv/cab_rect_ctrl.sv =====
// cab_rect_ctrl: clips a start item against the framebuffer and walks the raster.
// Depends on cab_pkg.
`default_nettype none

module cab_rect_ctrl
    import cab_pkg::*;
#(
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          go,
    input  wire item_kind_t                    kind,
    input  wire logic signed [COORD_BITS-1:0]  src_x,
    input  wire logic signed [COORD_BITS-1:0]  src_y,
    input  wire logic signed [COORD_BITS-1:0]  rect_width,
    input  wire logic signed [COORD_BITS-1:0]  rect_height,
    input  wire logic signed [COORD_BITS-1:0]  dest_x,
    input  wire logic signed [COORD_BITS-1:0]  dest_y,
    input  wire logic        [ALPHA_BITS-1:0]  alpha,
    input  wire logic        [FB_BITS-1:0]     fb_width,
    input  wire logic        [FB_BITS-1:0]     fb_height,
    output rect_ctx_t                          ctx,
    output logic             [OFFSET_BITS-1:0] src_row,
    output logic signed      [COORD_BITS:0]    src_x0
);

    localparam int CLIP_W = ((COORD_BITS > FB_BITS) ? COORD_BITS : FB_BITS) + 2;

    logic signed [CLIP_W-1:0] sx_e, sy_e, w_e, h_e, dx_e, dy_e, fbw_e, fbh_e;
    logic signed [CLIP_W-1:0] sx_c, sy_c, w1, h1, dx_c, dy_c, w2, h2;
    logic signed [CLIP_W+COORD_BITS-1:0] start_prod;
    logic empty;
    logic row_end;
    logic is_last;

    logic                          active_reg,  active_next;
    logic [FB_BITS-1:0]            row_reg,     row_next;
    logic [FB_BITS-1:0]            col_reg,     col_next;
    logic [FB_BITS-1:0]            clip_w_reg,  clip_w_next;
    logic [FB_BITS-1:0]            clip_h_reg,  clip_h_next;
    logic [FB_BITS-1:0]            dst_row_reg, dst_row_next;
    logic [FB_BITS-1:0]            dst_x0_reg,  dst_x0_next;
    logic [ALPHA_BITS-1:0]         alpha_reg,   alpha_next;
    logic [OFFSET_BITS-1:0]        src_row_reg, src_row_next;
    logic signed [COORD_BITS:0]    src_x0_reg,  src_x0_next;
    logic signed [COORD_BITS-1:0]  stride_reg,  stride_next;

    // Clip left/top, then right/bottom
    always_comb begin
        sx_e  = CLIP_W'(src_x);
        sy_e  = CLIP_W'(src_y);
        w_e   = CLIP_W'(rect_width);
        h_e   = CLIP_W'(rect_height);
        dx_e  = CLIP_W'(dest_x);
        dy_e  = CLIP_W'(dest_y);
        fbw_e = CLIP_W'(fb_width);
        fbh_e = CLIP_W'(fb_height);

        sx_c = sx_e;  w1 = w_e;  dx_c = dx_e;
        if (dx_e < 0) begin
            sx_c = sx_e - dx_e;
            w1   = w_e + dx_e;
            dx_c = '0;
        end
        sy_c = sy_e;  h1 = h_e;  dy_c = dy_e;
        if (dy_e < 0) begin
            sy_c = sy_e - dy_e;
            h1   = h_e + dy_e;
            dy_c = '0;
        end
        w2 = (dx_c + w1 > fbw_e) ? fbw_e - dx_c : w1;
        h2 = (dy_c + h1 > fbh_e) ? fbh_e - dy_c : h1;
        empty = (alpha == '0) || (w2 <= 0) || (h2 <= 0);
    end

    assign start_prod = sy_c * rect_width;

    assign row_end = (col_reg == clip_w_reg - FB_BITS'(1));
    assign is_last = row_end && (row_reg == clip_h_reg - FB_BITS'(1));

    always_comb begin
        active_next  = active_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        clip_w_next  = clip_w_reg;
        clip_h_next  = clip_h_reg;
        dst_row_next = dst_row_reg;
        dst_x0_next  = dst_x0_reg;
        alpha_next   = alpha_reg;
        src_row_next = src_row_reg;
        src_x0_next  = src_x0_reg;
        stride_next  = stride_reg;
        if (go) begin
            if (kind == KIND_START) begin
                // A start drops whatever rectangle was in flight
                active_next  = !empty;
                row_next     = '0;
                col_next     = '0;
                clip_w_next  = w2[FB_BITS-1:0];
                clip_h_next  = h2[FB_BITS-1:0];
                dst_row_next = dy_c[FB_BITS-1:0];
                dst_x0_next  = dx_c[FB_BITS-1:0];
                alpha_next   = alpha;
                src_row_next = OFFSET_BITS'(start_prod);
                src_x0_next  = sx_c[COORD_BITS:0];
                stride_next  = rect_width;
            end else if (active_reg) begin
                if (is_last) begin
                    active_next = 1'b0;
                    row_next    = '0;
                    col_next    = '0;
                end else if (row_end) begin
                    col_next     = '0;
                    row_next     = row_reg + FB_BITS'(1);
                    dst_row_next = dst_row_reg + FB_BITS'(1);
                    src_row_next = src_row_reg + OFFSET_BITS'(stride_reg);
                end else begin
                    col_next = col_reg + FB_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
        end else begin
            active_reg <= active_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        clip_w_reg  <= clip_w_next;
        clip_h_reg  <= clip_h_next;
        dst_row_reg <= dst_row_next;
        dst_x0_reg  <= dst_x0_next;
        alpha_reg   <= alpha_next;
        src_row_reg <= src_row_next;
        src_x0_reg  <= src_x0_next;
        stride_reg  <= stride_next;
    end

    assign ctx.active  = active_reg;
    assign ctx.last    = is_last;
    assign ctx.row     = row_reg;
    assign ctx.col     = col_reg;
    assign ctx.clip_w  = clip_w_reg;
    assign ctx.clip_h  = clip_h_reg;
    assign ctx.dst_row = dst_row_reg;
    assign ctx.dst_x0  = dst_x0_reg;
    assign ctx.alpha   = alpha_reg;
    assign src_row     = src_row_reg;
    assign src_x0      = src_x0_reg;

endmodule

`default_nettype wire

// ===== sv/clipped_alpha_blend_blitter.sv =====
// clipped_alpha_blend_blitter: top level of the clipped constant alpha blend blitter.
// Depends on cab_pkg, cab_rect_ctrl, cab_addr and cab_blend.
//
//  channel   direction  handshake               payload
//  s_*       in         s_valid / s_ready       kind, rectangle, alpha, src/dst pixel
//  m_*       out        m_valid / m_ready       dst_offset, src_offset, pixel_out, last
//  cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per clock sustained while m_ready stays high. A transfer lands in the input
// register; once the result register is free, clip/raster control, offset arithmetic
// and blend move it into the result register, which raises m_valid for a pixel item in
// an active rectangle. Reset (synchronous, aresetn low) clears the pipeline valids, the
// rectangle and the registers to their defaults. A stalled result holds; the input
// register still takes one more transfer, then s_ready drops. cfg_ready is always high.
`default_nettype none

module clipped_alpha_blend_blitter
    import cab_pkg::*;
#(
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_kind,
    input  wire logic signed [COORD_BITS-1:0] s_src_x,
    input  wire logic signed [COORD_BITS-1:0] s_src_y,
    input  wire logic signed [COORD_BITS-1:0] s_rect_width,
    input  wire logic signed [COORD_BITS-1:0] s_rect_height,
    input  wire logic signed [COORD_BITS-1:0] s_dest_x,
    input  wire logic signed [COORD_BITS-1:0] s_dest_y,
    input  wire logic        [ALPHA_BITS-1:0] s_alpha,
    input  wire logic        [PIX_BITS-1:0]   s_src_px,
    input  wire logic        [PIX_BITS-1:0]   s_dst_px,

    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic             [OUT_OFF_BITS-1:0] m_dst_offset,
    output logic             [OUT_OFF_BITS-1:0] m_src_offset,
    output logic             [PIX_BITS-1:0]   m_pixel_out,
    output logic                              m_last,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic        [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic        [CFG_DATA_BITS-1:0] cfg_data
);

    // ---------------- configuration registers ----------------
    logic [FB_BITS-1:0]    fb_width_reg;
    logic [FB_BITS-1:0]    fb_height_reg;
    logic [PITCH_BITS-1:0] row_pitch_reg;
    logic [BPP_BITS-1:0]   bpp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_width_reg  <= '0;
            fb_height_reg <= '0;
            row_pitch_reg <= '0;
            bpp_reg       <= BPP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_FB_WIDTH:        fb_width_reg  <= cfg_data[FB_BITS-1:0];
                REG_FB_HEIGHT:       fb_height_reg <= cfg_data[FB_BITS-1:0];
                REG_ROW_PITCH:       row_pitch_reg <= cfg_data[PITCH_BITS-1:0];
                REG_BYTES_PER_PIXEL: bpp_reg       <= cfg_data[BPP_BITS-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                         in_valid_reg;
    item_kind_t                   in_kind_reg;
    logic signed [COORD_BITS-1:0] in_src_x_reg, in_src_y_reg;
    logic signed [COORD_BITS-1:0] in_rect_w_reg, in_rect_h_reg;
    logic signed [COORD_BITS-1:0] in_dest_x_reg, in_dest_y_reg;
    logic        [ALPHA_BITS-1:0] in_alpha_reg;
    logic        [PIX_BITS-1:0]   in_src_pix_reg, in_dst_pix_reg;

    logic m_valid_reg;
    logic advance;   // result register free to load this edge
    logic in_go;     // input register item processed this edge
    logic produce;

    assign advance = !m_valid_reg || m_ready;
    assign in_go   = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Capture payload on every transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg    <= item_kind_t'(s_kind);
            in_src_x_reg   <= s_src_x;
            in_src_y_reg   <= s_src_y;
            in_rect_w_reg  <= s_rect_width;
            in_rect_h_reg  <= s_rect_height;
            in_dest_x_reg  <= s_dest_x;
            in_dest_y_reg  <= s_dest_y;
            in_alpha_reg   <= s_alpha;
            in_src_pix_reg <= s_src_px;
            in_dst_pix_reg <= s_dst_px;
        end
    end

    // ---------------- single pass logic ----------------
    rect_ctx_t                     ctx;
    logic [OFFSET_BITS-1:0]        src_row;
    logic signed [COORD_BITS:0]    src_x0;
    logic [OFFSET_BITS-1:0]        dst_off;
    logic [OFFSET_BITS-1:0]        src_off;
    logic [PIX_BITS-1:0]           pixel;

    cab_rect_ctrl #(
        .COORD_BITS  (COORD_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .go          (in_go),
        .kind        (in_kind_reg),
        .src_x       (in_src_x_reg),
        .src_y       (in_src_y_reg),
        .rect_width  (in_rect_w_reg),
        .rect_height (in_rect_h_reg),
        .dest_x      (in_dest_x_reg),
        .dest_y      (in_dest_y_reg),
        .alpha       (in_alpha_reg),
        .fb_width    (fb_width_reg),
        .fb_height   (fb_height_reg),
        .ctx         (ctx),
        .src_row     (src_row),
        .src_x0      (src_x0)
    );

    cab_addr #(
        .COORD_BITS  (COORD_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_addr (
        .dst_row   (ctx.dst_row),
        .dst_x0    (ctx.dst_x0),
        .col       (ctx.col),
        .row_pitch (row_pitch_reg),
        .bpp_cfg   (bpp_reg),
        .src_row   (src_row),
        .src_x0    (src_x0),
        .dst_off   (dst_off),
        .src_off   (src_off)
    );

    cab_blend u_blend (
        .src_px    (in_src_pix_reg),
        .dst_px    (in_dst_pix_reg),
        .alpha     (ctx.alpha),
        .bpp_cfg   (bpp_reg),
        .pixel_out (pixel)
    );

    // Only a pixel item inside an active rectangle yields a result
    assign produce = in_go && (in_kind_reg == KIND_PIXEL) && ctx.active;

    // ---------------- result register ----------------
    logic [OUT_OFF_BITS-1:0] m_dst_off_reg;
    logic [OUT_OFF_BITS-1:0] m_src_off_reg;
    logic [PIX_BITS-1:0]     m_pixel_reg;
    logic                    m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && produce) begin
            m_dst_off_reg <= OUT_OFF_BITS'(dst_off);
            m_src_off_reg <= OUT_OFF_BITS'(src_off);
            m_pixel_reg   <= pixel;
            m_last_reg    <= ctx.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_dst_offset = m_dst_off_reg;
    assign m_src_offset = m_src_off_reg;
    assign m_pixel_out  = m_pixel_reg;
    assign m_last       = m_last_reg;

    // ---------------- assertions ----------------
    // The final pixel closes the rectangle
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_go && (in_kind_reg == KIND_PIXEL) && ctx.active && ctx.last) |=> !ctx.active)
        else $error("rectangle still active after its last pixel");

    // A start with zero alpha leaves the block idle
    a_alpha_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_go && (in_kind_reg == KIND_START) && (in_alpha_reg == '0)) |=> !ctx.active)
        else $error("zero alpha start opened a rectangle");

    // Raster position stays inside the clipped rectangle
    a_pos_in_rect: assert property (@(posedge aclk) disable iff (!aresetn)
        ctx.active |-> ((ctx.row < ctx.clip_h) && (ctx.col < ctx.clip_w)))
        else $error("raster position outside clipped rectangle");

endmodule

`default_nettype wire
